// File: sv/vsm_pkg.sv
// shared types and constants for the temporal-variance soft mask
package vsm_pkg;

    localparam int MAG_W           = 16;
    localparam int RES_W           = MAG_W + 1;
    localparam int ENT_W           = RES_W + MAG_W;
    localparam int HS_W            = 6;
    localparam int BIN_OUT_W       = 10;
    localparam int MASK_W          = 16;
    localparam int FRAC_BITS       = 15;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam int HISTORY_MAX_DEF = 32;
    localparam int NUM_BINS_DEF    = 1024;

    localparam logic [HS_W-1:0]   HS_RESET = HS_W'(8);
    localparam logic [MASK_W-1:0] MASK_ONE = MASK_W'(1) << FRAC_BITS;

    // register index, taken from paddr[2]
    localparam logic REG_HISTORY_SIZE = 1'b0;

    typedef struct packed {
        logic [MAG_W-1:0] mixture_magnitude;
        logic [MAG_W-1:0] source_magnitude;
        logic             last_in_frame;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0]    mask_value;
        logic [BIN_OUT_W-1:0] bin_number;
        logic                 frame_end;
    } out_item_t;

endpackage

// File: sv/variance_soft_mask_over_time.sv
// temporal-variance soft mask: sequencer, history memory and shared multiplier
//
// Input channel s_*: one spectral bin per transaction, in bin order, with
// mixture and source magnitudes; last_in_frame marks the last bin of a frame.
// Output channel m_*: one mask transaction per input, with bin index and
// frame-end echo. Configuration: APB register history_size (H) at address 0;
// a write clears the history and restarts at bin 0 of a new first frame.
// Each bin works alone: s_ready is high only while the sequencer is idle.
// With a filled history and H >= 2, a bin passes through these steps in order:
// idle to accept it, one write, one read, then SQS, SQR and ACC for each
// stored frame through the single history read port and the shared
// multiplier, the finish steps that form both variances, the bit-serial
// divider, and the output state that loads the result; the next bin is taken
// only after that. During the first frame every bin is written into all H
// slots. With H = 1 the mask is source / mixture and no history is read.
// A finished result waits in the output register; while the receiver stalls
// the next bin is accepted and worked on, and only its own result waits.
// Reset (synchronous, aresetn low) sets H to 8 and empties the history;
// the history memory itself is not cleared and needs no sweep.
module variance_soft_mask_over_time #(
    parameter int HISTORY_MAX = vsm_pkg::HISTORY_MAX_DEF,
    parameter int NUM_BINS    = vsm_pkg::NUM_BINS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  vsm_pkg::in_item_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output vsm_pkg::out_item_t           m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vsm_pkg::PADDR_W-1:0]  paddr,
    input  logic [vsm_pkg::PDATA_W-1:0]  pwdata,
    output logic [vsm_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import vsm_pkg::*;

    localparam int HW    = $clog2(HISTORY_MAX + 1);
    localparam int BW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int DEPTH = HISTORY_MAX * NUM_BINS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW    = MAG_W + HW;
    localparam int SQW   = 2 * MAG_W + HW;
    localparam int VW    = 2 * MW;
    localparam int CW    = (HW > HS_W) ? HW + 1 : HS_W + 1;
    localparam int BXW   = BW + BIN_OUT_W;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_WRITE = 9'b000000010,
        ST_RD    = 9'b000000100,
        ST_SQS   = 9'b000001000,
        ST_SQR   = 9'b000010000,
        ST_ACC   = 9'b000100000,
        ST_FIN   = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t            state_reg;
    logic [HS_W-1:0]   hs_reg;
    logic              primed_reg;
    logic [HW-1:0]     slot_reg;
    logic [AW-1:0]     slot_base_reg;
    logic [BW-1:0]     bin_reg;
    in_item_t          in_reg;
    logic [HW-1:0]     k_reg;
    logic [AW-1:0]     addr_reg;
    logic [ENT_W-1:0]  rd_data_reg;
    logic [VW-1:0]     mult_reg;
    logic [MW-1:0]     sum_s_reg;
    logic signed [MW:0] sum_r_reg;
    logic [SQW-1:0]    sq_s_reg;
    logic [SQW-1:0]    sq_r_reg;
    logic [VW-1:0]     var_s_reg;
    logic [VW:0]       var_r_reg;
    logic [2:0]        fin_step_reg;
    logic              div_start_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic [ENT_W-1:0]  mem [DEPTH];

    logic              cfg_wr;
    logic [CW-1:0]     hs_ext;
    logic [HW-1:0]     h_eff;
    logic [RES_W-1:0]  res_in;
    logic [AW-1:0]     addr_step;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [MAG_W-1:0]  rd_src;
    logic [RES_W-1:0]  rd_res;
    logic [RES_W-1:0]  rd_res_abs;
    logic [MW:0]       sum_r_abs;
    logic [MW-1:0]     mul_a;
    logic [MW-1:0]     mul_b;
    logic [MW-1:0]     h_mw;
    logic              last_k;
    logic              div_go;
    logic              div_done;
    logic [MASK_W-1:0] div_quot;
    logic [BXW-1:0]    bin_ext;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HISTORY_SIZE) ? PDATA_W'(hs_reg) : '0;

    // out-of-range sizes: zero acts as one, above the maximum clamps
    assign hs_ext = CW'(hs_reg);
    always_comb begin
        if (hs_ext == '0) begin
            h_eff = HW'(1);
        end else if (hs_ext > CW'(HISTORY_MAX)) begin
            h_eff = HW'(HISTORY_MAX);
        end else begin
            h_eff = HW'(hs_ext);
        end
    end

    assign res_in     = {1'b0, in_reg.mixture_magnitude} - {1'b0, in_reg.source_magnitude};
    assign addr_step  = addr_reg + AW'(NUM_BINS);
    assign last_k     = (k_reg + HW'(1)) == h_eff;
    assign rd_addr    = (state_reg == ST_ACC) ? addr_step : addr_reg;
    assign mem_we     = (state_reg == ST_WRITE);
    assign rd_src     = rd_data_reg[MAG_W-1:0];
    assign rd_res     = rd_data_reg[ENT_W-1:MAG_W];
    assign rd_res_abs = rd_res[RES_W-1] ? (RES_W'(0) - rd_res) : rd_res;
    assign sum_r_abs  = sum_r_reg[MW] ? ((MW+1)'(0) - sum_r_reg) : sum_r_reg;
    assign h_mw       = MW'(h_eff);

    // divider starts after the last write (first frame or one frame) or the last finish step
    assign div_go = ((state_reg == ST_WRITE) && (primed_reg || last_k)
                     && ((h_eff == HW'(1)) || !primed_reg))
                 || ((state_reg == ST_FIN) && (fin_step_reg == 3'd7));

    // history memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_reg] <= {res_in, in_reg.source_magnitude};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQS: begin
                mul_a = MW'(rd_src);
                mul_b = MW'(rd_src);
            end
            ST_SQR: begin
                mul_a = MW'(rd_res_abs[MAG_W-1:0]);
                mul_b = MW'(rd_res_abs[MAG_W-1:0]);
            end
            ST_FIN: begin
                unique case (fin_step_reg)
                    3'd0: begin
                        mul_a = h_mw;
                        mul_b = sq_s_reg[MW-1:0];
                    end
                    3'd1: begin
                        mul_a = h_mw;
                        mul_b = MW'(sq_s_reg[SQW-1:MW]);
                    end
                    3'd2: begin
                        mul_a = sum_s_reg;
                        mul_b = sum_s_reg;
                    end
                    3'd3: begin
                        mul_a = h_mw;
                        mul_b = sq_r_reg[MW-1:0];
                    end
                    3'd4: begin
                        mul_a = h_mw;
                        mul_b = MW'(sq_r_reg[SQW-1:MW]);
                    end
                    3'd5: begin
                        mul_a = sum_r_abs[MW-1:0];
                        mul_b = sum_r_abs[MW-1:0];
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mult_reg <= mul_a * mul_b;
    end

    vsm_div #(
        .DW(VW + 1)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     ({1'b0, var_s_reg}),
        .den     (var_r_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hs_reg        <= HS_RESET;
            primed_reg    <= 1'b0;
            slot_reg      <= '0;
            slot_base_reg <= '0;
            bin_reg       <= '0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            div_start_reg <= div_go;
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        k_reg     <= '0;
                        addr_reg  <= primed_reg ? (slot_base_reg + AW'(bin_reg))
                                                : AW'(bin_reg);
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    if (primed_reg || last_k) begin
                        k_reg     <= '0;
                        addr_reg  <= AW'(bin_reg);
                        sum_s_reg <= '0;
                        sum_r_reg <= '0;
                        sq_s_reg  <= '0;
                        sq_r_reg  <= '0;
                        if (h_eff == HW'(1)) begin
                            // one frame: ratio of source to mixture
                            var_s_reg <= VW'(in_reg.source_magnitude);
                            var_r_reg <= (VW+1)'(in_reg.mixture_magnitude);
                            state_reg <= ST_DIV;
                        end else if (!primed_reg) begin
                            // all slots equal, both variances vanish
                            var_s_reg <= '0;
                            var_r_reg <= '0;
                            state_reg <= ST_DIV;
                        end else begin
                            state_reg <= ST_RD;
                        end
                    end else begin
                        k_reg    <= k_reg + HW'(1);
                        addr_reg <= addr_step;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_SQS;
                end
                ST_SQS: begin
                    sum_s_reg <= sum_s_reg + MW'(rd_src);
                    sum_r_reg <= sum_r_reg + {{(MW+1-RES_W){rd_res[RES_W-1]}}, rd_res};
                    state_reg <= ST_SQR;
                end
                ST_SQR: begin
                    sq_s_reg  <= sq_s_reg + SQW'(mult_reg);
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    sq_r_reg <= sq_r_reg + SQW'(mult_reg);
                    if (last_k) begin
                        fin_step_reg <= '0;
                        state_reg    <= ST_FIN;
                    end else begin
                        k_reg     <= k_reg + HW'(1);
                        addr_reg  <= addr_step;
                        state_reg <= ST_SQS;
                    end
                end
                ST_FIN: begin
                    fin_step_reg <= fin_step_reg + 3'd1;
                    unique case (fin_step_reg)
                        3'd1: var_s_reg <= mult_reg;
                        3'd2: var_s_reg <= var_s_reg + (mult_reg << MW);
                        3'd3: var_s_reg <= var_s_reg - mult_reg;
                        3'd4: var_r_reg <= {1'b0, mult_reg};
                        3'd5: var_r_reg <= {1'b0, VW'(var_r_reg[VW-1:0] + (mult_reg << MW))};
                        3'd6: var_r_reg <= {1'b0, VW'(var_r_reg[VW-1:0] - mult_reg)};
                        3'd7: begin
                            var_r_reg <= {1'b0, var_s_reg} + var_r_reg;
                            state_reg <= ST_DIV;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_DIV: begin
                    if (div_done) begin
                        mask_reg  <= div_quot;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.mask_value <= mask_reg;
                        m_data_reg.bin_number <= bin_ext[BIN_OUT_W-1:0];
                        m_data_reg.frame_end  <= in_reg.last_in_frame;
                        if (in_reg.last_in_frame) begin
                            bin_reg    <= '0;
                            primed_reg <= 1'b1;
                            if ((slot_reg + HW'(1)) == h_eff) begin
                                slot_reg      <= '0;
                                slot_base_reg <= '0;
                            end else begin
                                slot_reg      <= slot_reg + HW'(1);
                                slot_base_reg <= slot_base_reg + AW'(NUM_BINS);
                            end
                        end else if (bin_reg == BW'(NUM_BINS - 1)) begin
                            bin_reg <= '0;
                        end else begin
                            bin_reg <= bin_reg + BW'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // a size write restarts the history
            if (cfg_wr && (paddr[2] == REG_HISTORY_SIZE)) begin
                hs_reg        <= pwdata[HS_W-1:0];
                primed_reg    <= 1'b0;
                slot_reg      <= '0;
                slot_base_reg <= '0;
                bin_reg       <= '0;
            end
        end
    end

    assign bin_ext = BXW'(bin_reg);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again before the transaction finished");

    a_mask_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.mask_value <= MASK_ONE)
        else $error("mask above one");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg < h_eff)
        else $error("frame slot outside history");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide phase");

endmodule

// File: sv/vsm_div.sv
// restoring divider for the Q1.15 mask ratio, one quotient bit per cycle
module vsm_div #(
    parameter int DW = 45
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [DW-1:0]             num,
    input  logic [DW-1:0]             den,
    output logic                      done,
    output logic [vsm_pkg::MASK_W-1:0] quot
);
    import vsm_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     den_reg;
    logic [MASK_W-1:0] quot_reg;
    logic [DW:0]       shifted;
    logic              take;

    assign shifted = {rem_reg, 1'b0};
    assign take    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                den_reg <= den;
                rem_reg <= num;
                if (den == '0) begin
                    quot_reg <= '0;
                    done_reg <= 1'b1;
                end else if (num >= den) begin
                    quot_reg <= MASK_ONE;
                    done_reg <= 1'b1;
                end else begin
                    quot_reg <= '0;
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(FRAC_BITS);
                end
            end else if (busy_reg) begin
                rem_reg  <= take ? DW'(shifted - {1'b0, den_reg}) : DW'(shifted);
                quot_reg <= {quot_reg[MASK_W-2:0], take};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
